@@ rtl/ppsi_pkg.sv @@
// Shared types and constants for the PPPoE session header insertion block.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none
package ppsi_pkg;

   localparam logic [15:0] ETH_TYPE_IPV4       = 16'h0800;
   localparam logic [15:0] ETH_TYPE_IPV6       = 16'h86DD;
   localparam logic [15:0] ETH_TYPE_PPPOE_SESS = 16'h8864;
   localparam logic [15:0] PPP_PROTO_IPV4      = 16'h0021;
   localparam logic [15:0] PPP_PROTO_IPV6      = 16'h0057;
   localparam logic [7:0]  PPPOE_VER_TYPE      = 8'h11;
   localparam logic [7:0]  PPPOE_CODE_SESSION  = 8'h00;
   localparam logic [15:0] MAC_HDR_BYTES       = 16'd12;

   localparam logic [3:0] TYPE_POS_HI = 4'd12;
   localparam logic [3:0] TYPE_POS_LO = 4'd13;
   localparam logic [3:0] POS_SAT     = 4'd14;

   localparam int          BURST_LEN      = 10;
   localparam logic [3:0]  BURST_LAST_IDX = 4'd9;
   localparam logic [3:0]  PAIR_LAST_IDX  = 4'd1;
   localparam logic [3:0]  PASS_LAST_IDX  = 4'd0;

   typedef enum logic [1:0] {
      JOB_PASS,    // one byte out unchanged
      JOB_PAIR,    // held type byte, then current byte
      JOB_INSERT   // ten-byte PPPoE type and session header
   } ppsi_job_kind_type;

   typedef struct packed {
      ppsi_job_kind_type kind;
      logic [7:0]        data;
      logic [7:0]        held;
      logic              last;
      logic [15:0]       pppoe_len;
      logic              is_ipv6;
   } ppsi_job_type;

   typedef struct packed {
      logic [3:0] pos;
      logic [7:0] held;
   } ppsi_front_status_type;

endpackage
`default_nettype wire

@@ rtl/ppsi_if.sv @@
// Channel interfaces of the PPPoE session header insertion block:
// request byte stream, result byte stream and session register write port.
`default_nettype none
interface ppsi_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  in_byte;
   logic        in_last;
   logic [15:0] frame_length;
   modport source (output valid, in_byte, in_last, frame_length, input ready);
   modport sink   (input valid, in_byte, in_last, frame_length, output ready);
endinterface

interface ppsi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       run_end;
   modport source (output valid, out_byte, frame_end, run_end, input ready);
   modport sink   (input valid, out_byte, frame_end, run_end, output ready);
endinterface

interface ppsi_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/ppsi_front.sv @@
// Front end: accepts frame bytes, tracks the header position and classifies
// each byte into an emit job. Depends on ppsi_pkg and ppsi_req_if.
`default_nettype none
module ppsi_front
   import ppsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ppsi_req_if.sink              req_chan,
   input  logic                  q_full,
   output logic                  push_valid,
   output ppsi_job_type          push_job,
   output ppsi_front_status_type status
);

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  held_ff, held_in;
   logic        accept;
   logic [15:0] etype;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign etype          = {held_ff, req_chan.in_byte};
   assign status         = '{pos: pos_ff, held: held_ff};

   always_comb begin
      pos_in             = pos_ff;
      held_in            = held_ff;
      push_valid         = 1'b0;
      push_job.kind      = JOB_PASS;
      push_job.data      = req_chan.in_byte;
      push_job.held      = held_ff;
      push_job.last      = req_chan.in_last;
      push_job.pppoe_len = req_chan.frame_length - MAC_HDR_BYTES;
      push_job.is_ipv6   = (etype == ETH_TYPE_IPV6);
      if (accept) begin
         if (pos_ff == TYPE_POS_HI) begin
            // hold the first type byte; emit it alone only if the frame ends here
            held_in    = req_chan.in_byte;
            push_valid = req_chan.in_last;
         end else if (pos_ff == TYPE_POS_LO) begin
            push_valid = 1'b1;
            if (etype == ETH_TYPE_IPV4 || etype == ETH_TYPE_IPV6) begin
               push_job.kind = JOB_INSERT;
            end else begin
               push_job.kind = JOB_PAIR;
            end
         end else begin
            push_valid = 1'b1;
         end
         if (req_chan.in_last) begin
            pos_in = '0;
         end else if (pos_ff < POS_SAT) begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         held_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/ppsi_queue.sv @@
// Short job queue between front and back end, kept in flip-flops.
// Depends on ppsi_pkg for the job type.
`default_nettype none
module ppsi_queue
   import ppsi_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ppsi_job_type push_job,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output ppsi_job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ppsi_job_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ rtl/ppsi_back.sv @@
// Back end: expands the head job into output bytes into a registered result.
// Depends on ppsi_pkg and ppsi_rsp_if.
`default_nettype none
module ppsi_back
   import ppsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  ppsi_job_type job,
   input  logic [15:0]  session,
   output logic         pop,
   ppsi_rsp_if.source   rsp_chan
);

   logic [3:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        frame_end_ff, frame_end_in;
   logic        run_end_ff, run_end_in;
   logic        load_en, final_idx;
   logic [3:0]  last_idx;
   logic [15:0] proto;
   logic [7:0]  hdr [BURST_LEN];
   logic [7:0]  cur_byte;

   assign proto  = job.is_ipv6 ? PPP_PROTO_IPV6 : PPP_PROTO_IPV4;
   assign hdr[0] = ETH_TYPE_PPPOE_SESS[15:8];
   assign hdr[1] = ETH_TYPE_PPPOE_SESS[7:0];
   assign hdr[2] = PPPOE_VER_TYPE;
   assign hdr[3] = PPPOE_CODE_SESSION;
   assign hdr[4] = session[15:8];
   assign hdr[5] = session[7:0];
   assign hdr[6] = job.pppoe_len[15:8];
   assign hdr[7] = job.pppoe_len[7:0];
   assign hdr[8] = proto[15:8];
   assign hdr[9] = proto[7:0];

   always_comb begin
      case (job.kind)
         JOB_INSERT: begin
            last_idx = BURST_LAST_IDX;
            cur_byte = hdr[idx_ff];
         end
         JOB_PAIR: begin
            last_idx = PAIR_LAST_IDX;
            cur_byte = (idx_ff == '0) ? job.held : job.data;
         end
         default: begin
            last_idx = PASS_LAST_IDX;
            cur_byte = job.data;
         end
      endcase
   end

   assign final_idx = (idx_ff == last_idx);
   assign load_en   = !out_valid_ff || rsp_chan.ready;
   assign pop       = load_en && job_valid && final_idx;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      frame_end_in = frame_end_ff;
      run_end_in   = run_end_ff;
      if (load_en) begin
         out_valid_in = job_valid;
         if (job_valid) begin
            out_byte_in  = cur_byte;
            frame_end_in = final_idx && job.last;
            run_end_in   = final_idx;
            idx_in       = final_idx ? '0 : idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      frame_end_ff <= frame_end_in;
      run_end_ff   <= run_end_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.frame_end = frame_end_ff;
   assign rsp_chan.run_end   = run_end_ff;

endmodule
`default_nettype wire

@@ rtl/pppoe_session_header_insert.sv @@
// Top level of the PPPoE session header insertion block.
// Depends on ppsi_pkg, ppsi_if, ppsi_front, ppsi_queue and ppsi_back.
//
// Usage:
//   req_chan carries an Ethernet frame one byte per item (in_byte, in_last,
//   frame_length). rsp_chan returns the rewritten frame one byte per item,
//   with frame_end on the final byte and run_end on the last byte that an
//   input item causes. csr_chan writes the 16-bit session id; it is always
//   ready and should be written only while the block is idle.
//   For an IPv4 or IPv6 frame, the two EtherType bytes are replaced by a
//   ten-byte burst: type 0x8864, ver/type, code, session id, length
//   (frame_length - 12) and PPP protocol. Other frames pass unchanged.
// Path: the front end writes the job queue at the edge that accepts an
//   input item; the back end loads the output register from the queue head
//   when the register is empty or its byte is being taken, and rsp_chan is
//   driven from the register.
// Throughput: one input item and one result byte per cycle unless stalled;
//   the header burst adds eight output bytes per inserted frame, absorbed by
//   the job queue (QUEUE_DEPTH entries) before req_chan.ready drops.
// Reset: synchronous; clears the frame position, held type byte, queue,
//   output valid flag and the session id (to zero).
// Stall: when rsp_chan.ready is low the output register holds its byte;
//   the queue fills and then req_chan.ready drops until space frees.
`default_nettype none
module pppoe_session_header_insert
   import ppsi_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   ppsi_req_if.sink  req_chan,
   ppsi_rsp_if.source rsp_chan,
   ppsi_csr_if.sink  csr_chan
);

   logic [15:0]           session_ff, session_in;
   logic                  q_full, q_empty, push_valid, pop;
   ppsi_job_type          push_job, head_job;
   ppsi_front_status_type front_status;

   // Session id register: always accept a write.
   assign csr_chan.ready = 1'b1;
   assign session_in     = csr_chan.valid ? csr_chan.data : session_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff <= '0;
      end else begin
         session_ff <= session_in;
      end
   end

   // Classify incoming bytes into emit jobs.
   ppsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job),
      .status     (front_status)
   );

   // Decouple the classifier from the byte expander.
   ppsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (head_job)
   );

   // Expand jobs into output bytes.
   ppsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job       (head_job),
      .session   (session_ff),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // The front end never pushes into a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("job pushed into full queue");

   // The back end never pops an empty queue.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("job popped from empty queue");

   // A frame's last byte restarts the position count.
   a_pos_restart : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.in_last) |=> front_status.pos == '0)
      else $error("position not cleared after last byte");

   // A popped job always ends with a run_end result in the output register.
   a_pop_run_end : assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_chan.valid && rsp_chan.run_end))
      else $error("job retired without run_end");

endmodule
`default_nettype wire
